[design/sexpr_token_scanner_unit_assert.svh]
// Assertion helpers shared by the scanner RTL.
// Each macro builds one labeled concurrent assertion that is sampled on the
// rising clock edge and switched off while the active-low reset is asserted.
`ifndef SEXPR_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define SEXPR_TOKEN_SCANNER_UNIT_ASSERT_SVH

// The expression holds at every sampled edge.
`define STS_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define STS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define STS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[design/sts_pkg.sv]
`timescale 1ns / 1ps

package sts_pkg;

  localparam int unsigned POS_BITS_DEF = 16;
  localparam int unsigned POS_OUT_W    = 16;
  localparam int unsigned MAX_RES      = 5;
  localparam int unsigned CNT_W        = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W        = $clog2(MAX_RES);

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_T       = 8'h74;

  typedef enum logic [1:0] {
    EV_CHAR  = 2'd0,
    EV_END   = 2'd1,
    EV_ERROR = 2'd2,
    EV_EOI   = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    K_LPAREN = 3'd0,
    K_RPAREN = 3'd1,
    K_SYMBOL = 3'd2,
    K_INT    = 3'd3,
    K_FLOAT  = 3'd4,
    K_STRING = 3'd5,
    K_DOT    = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_DOT_DIGIT   = 3'd1,
    ERR_NO_FRACTION = 3'd2,
    ERR_BAD_NUMBER  = 3'd3,
    ERR_OPEN_STRING = 3'd4,
    ERR_BAD_ESCAPE  = 3'd5,
    ERR_DOT_SYMBOL  = 3'd6
  } err_e;

  typedef enum logic [8:0] {
    M_IDLE  = 9'b000000001,
    M_PDOT  = 9'b000000010,
    M_PSIGN = 9'b000000100,
    M_INT   = 9'b000001000,
    M_FRAC0 = 9'b000010000,
    M_FRAC  = 9'b000100000,
    M_STR   = 9'b001000000,
    M_ESC   = 9'b010000000,
    M_SYM   = 9'b100000000
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] pending;
    logic       halted;
  } scan_ctl_t;

  typedef struct packed {
    event_e                 ev;
    kind_e                  kind;
    logic [7:0]             value;
    logic [POS_OUT_W-1:0]   line;
    logic [POS_OUT_W-1:0]   column;
    err_e                   err;
    logic                   eor;
  } result_t;

  typedef result_t [MAX_RES-1:0] bundle_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return is_space(c) || (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_QUOTE);
  endfunction

  function automatic result_t char_res(input kind_e k, input logic [7:0] v,
                                       input logic [POS_OUT_W-1:0] ln,
                                       input logic [POS_OUT_W-1:0] col);
    return '{ev: EV_CHAR, kind: k, value: v, line: ln, column: col,
             err: ERR_NONE, eor: 1'b0};
  endfunction

  function automatic result_t end_res(input kind_e k,
                                      input logic [POS_OUT_W-1:0] ln,
                                      input logic [POS_OUT_W-1:0] col);
    return '{ev: EV_END, kind: k, value: 8'h00, line: ln, column: col,
             err: ERR_NONE, eor: 1'b0};
  endfunction

  function automatic result_t err_res(input err_e code,
                                      input logic [POS_OUT_W-1:0] ln,
                                      input logic [POS_OUT_W-1:0] col);
    return '{ev: EV_ERROR, kind: K_LPAREN, value: 8'h00, line: ln, column: col,
             err: code, eor: 1'b0};
  endfunction

  function automatic result_t eoi_res(input logic [POS_OUT_W-1:0] ln,
                                      input logic [POS_OUT_W-1:0] col);
    return '{ev: EV_EOI, kind: K_LPAREN, value: 8'h00, line: ln, column: col,
             err: ERR_NONE, eor: 1'b0};
  endfunction

  // Appends one result to a bundle; extra results beyond the bundle size are dropped.
  function automatic void push_res(inout bundle_t b, inout logic [CNT_W-1:0] n,
                                   input result_t r);
    if (n < CNT_W'(MAX_RES)) begin
      b[n[IDX_W-1:0]] = r;
      n = n + CNT_W'(1);
    end
  endfunction

endpackage

[design/sts_if.sv]
`timescale 1ns / 1ps

interface sts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface sts_event_if import sts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  event_e               event_res;
  kind_e                kind;
  logic [7:0]           value;
  logic [POS_OUT_W-1:0] line;
  logic [POS_OUT_W-1:0] column;
  err_e                 error_code;
  logic                 end_of_run;

  modport source (output valid, output event_res, output kind, output value,
                  output line, output column, output error_code,
                  output end_of_run, input ready);
  modport sink (input valid, input event_res, input kind, input value,
                input line, input column, input error_code,
                input end_of_run, output ready);
endinterface

[design/sts_scan_core.sv]
`timescale 1ns / 1ps

module sts_scan_core import sts_pkg::*; #(
  parameter int unsigned POSITION_BITS = POS_BITS_DEF
) (
  input  logic [7:0]               ch_i,
  input  logic                     last_i,
  input  scan_ctl_t                ctl_i,
  input  logic [POSITION_BITS-1:0] cur_line_i,
  input  logic [POSITION_BITS-1:0] cur_col_i,
  input  logic [POSITION_BITS-1:0] start_line_i,
  input  logic [POSITION_BITS-1:0] start_col_i,
  output scan_ctl_t                ctl_o,
  output logic [POSITION_BITS-1:0] cur_line_o,
  output logic [POSITION_BITS-1:0] cur_col_o,
  output logic [POSITION_BITS-1:0] start_line_o,
  output logic [POSITION_BITS-1:0] start_col_o,
  output bundle_t                  bundle_o,
  output logic [CNT_W-1:0]         count_o
);

  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);

  logic [POSITION_BITS-1:0] nl, nc;

  // Positions after this byte, saturating at the counter limit.
  always_comb begin
    nl = cur_line_i;
    nc = cur_col_i;
    if (ch_i == CH_NEWLINE) begin
      if (cur_line_i != PosMax) nl = cur_line_i + PosOne;
      nc = PosOne;
    end else if (cur_col_i != PosMax) begin
      nc = cur_col_i + PosOne;
    end
  end

  // A byte is looked at by at most three consecutive mode handlers: a pending
  // sign falls into a symbol, whose end hands the byte back to the idle handler.
  always_comb begin : scan
    mode_e                    mode;
    logic [7:0]               pend;
    logic                     halt;
    logic                     go;
    logic [POSITION_BITS-1:0] sl, sc;
    bundle_t                  b;
    logic [CNT_W-1:0]         n;

    mode = ctl_i.mode;
    pend = ctl_i.pending;
    halt = ctl_i.halted;
    go   = !ctl_i.halted;
    sl   = start_line_i;
    sc   = start_col_i;
    b    = '0;
    n    = '0;

    for (int pass = 0; pass < 3; pass++) begin
      if (go) begin
        go = 1'b0;
        unique case (mode)
          M_IDLE: begin
            if (!is_space(ch_i)) begin
              sl = cur_line_i;
              sc = cur_col_i;
              if (ch_i == CH_LPAREN || ch_i == CH_RPAREN) begin
                push_res(b, n, char_res((ch_i == CH_LPAREN) ? K_LPAREN : K_RPAREN, ch_i,
                                        POS_OUT_W'(sl), POS_OUT_W'(sc)));
                push_res(b, n, end_res((ch_i == CH_LPAREN) ? K_LPAREN : K_RPAREN,
                                       POS_OUT_W'(sl), POS_OUT_W'(sc)));
              end else if (ch_i == CH_DOT) begin
                mode = M_PDOT;
                pend = ch_i;
              end else if (ch_i == CH_QUOTE) begin
                mode = M_STR;
              end else if (is_digit(ch_i)) begin
                push_res(b, n, char_res(K_INT, ch_i, POS_OUT_W'(sl), POS_OUT_W'(sc)));
                mode = M_INT;
              end else if (ch_i == CH_PLUS || ch_i == CH_MINUS) begin
                mode = M_PSIGN;
                pend = ch_i;
              end else begin
                mode = M_SYM;
                go   = 1'b1;
              end
            end
          end
          M_PDOT: begin
            if (is_digit(ch_i)) begin
              push_res(b, n, err_res(ERR_DOT_DIGIT, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              halt = 1'b1;
              mode = M_IDLE;
            end else begin
              push_res(b, n, char_res(K_DOT, CH_DOT, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              push_res(b, n, end_res(K_DOT, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              mode = M_IDLE;
              go   = 1'b1;
            end
          end
          M_PSIGN: begin
            if (is_digit(ch_i)) begin
              push_res(b, n, char_res(K_INT, pend, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              push_res(b, n, char_res(K_INT, ch_i, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              mode = M_INT;
            end else begin
              push_res(b, n, char_res(K_SYMBOL, pend, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              mode = M_SYM;
              go   = 1'b1;
            end
          end
          M_INT, M_FRAC: begin
            if (is_digit(ch_i)) begin
              push_res(b, n, char_res((mode == M_INT) ? K_INT : K_FLOAT, ch_i,
                                      POS_OUT_W'(sl), POS_OUT_W'(sc)));
            end else if (ch_i == CH_DOT && mode == M_INT) begin
              push_res(b, n, char_res(K_FLOAT, ch_i, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              mode = M_FRAC0;
            end else if (is_delim(ch_i)) begin
              push_res(b, n, end_res((mode == M_INT) ? K_INT : K_FLOAT,
                                     POS_OUT_W'(sl), POS_OUT_W'(sc)));
              mode = M_IDLE;
              go   = 1'b1;
            end else begin
              push_res(b, n, err_res(ERR_BAD_NUMBER, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              halt = 1'b1;
              mode = M_IDLE;
            end
          end
          M_FRAC0: begin
            if (is_digit(ch_i)) begin
              push_res(b, n, char_res(K_FLOAT, ch_i, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              mode = M_FRAC;
            end else begin
              push_res(b, n, err_res(ERR_NO_FRACTION, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              halt = 1'b1;
              mode = M_IDLE;
            end
          end
          M_STR: begin
            if (ch_i == CH_QUOTE) begin
              push_res(b, n, end_res(K_STRING, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              mode = M_IDLE;
            end else if (ch_i == CH_BSLASH) begin
              mode = M_ESC;
            end else begin
              push_res(b, n, char_res(K_STRING, ch_i, POS_OUT_W'(sl), POS_OUT_W'(sc)));
            end
          end
          M_ESC: begin
            if (ch_i == CH_N) begin
              push_res(b, n, char_res(K_STRING, CH_NEWLINE, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              mode = M_STR;
            end else if (ch_i == CH_T) begin
              push_res(b, n, char_res(K_STRING, CH_TAB, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              mode = M_STR;
            end else if (ch_i == CH_QUOTE || ch_i == CH_BSLASH) begin
              push_res(b, n, char_res(K_STRING, ch_i, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              mode = M_STR;
            end else begin
              // The bad escape is reported just past the escaped byte.
              push_res(b, n, err_res(ERR_BAD_ESCAPE, POS_OUT_W'(nl), POS_OUT_W'(nc)));
              halt = 1'b1;
              mode = M_IDLE;
            end
          end
          M_SYM: begin
            if (is_delim(ch_i)) begin
              push_res(b, n, end_res(K_SYMBOL, POS_OUT_W'(sl), POS_OUT_W'(sc)));
              mode = M_IDLE;
              go   = 1'b1;
            end else if (ch_i == CH_DOT) begin
              push_res(b, n, err_res(ERR_DOT_SYMBOL, POS_OUT_W'(cur_line_i),
                                     POS_OUT_W'(cur_col_i)));
              halt = 1'b1;
              mode = M_IDLE;
            end else begin
              push_res(b, n, char_res(K_SYMBOL, ch_i, POS_OUT_W'(sl), POS_OUT_W'(sc)));
            end
          end
          default: begin
            mode = M_IDLE;
            go   = 1'b1;
          end
        endcase
      end
    end

    if (last_i) begin
      // Complete whatever token is still open, then report end of input.
      if (!halt) begin
        unique case (mode)
          M_PDOT: begin
            push_res(b, n, char_res(K_DOT, CH_DOT, POS_OUT_W'(sl), POS_OUT_W'(sc)));
            push_res(b, n, end_res(K_DOT, POS_OUT_W'(sl), POS_OUT_W'(sc)));
          end
          M_PSIGN: begin
            push_res(b, n, char_res(K_SYMBOL, pend, POS_OUT_W'(sl), POS_OUT_W'(sc)));
            push_res(b, n, end_res(K_SYMBOL, POS_OUT_W'(sl), POS_OUT_W'(sc)));
          end
          M_INT:   push_res(b, n, end_res(K_INT, POS_OUT_W'(sl), POS_OUT_W'(sc)));
          M_FRAC:  push_res(b, n, end_res(K_FLOAT, POS_OUT_W'(sl), POS_OUT_W'(sc)));
          M_FRAC0: push_res(b, n, err_res(ERR_NO_FRACTION, POS_OUT_W'(sl), POS_OUT_W'(sc)));
          M_STR, M_ESC: begin
            push_res(b, n, err_res(ERR_OPEN_STRING, POS_OUT_W'(sl), POS_OUT_W'(sc)));
          end
          M_SYM:   push_res(b, n, end_res(K_SYMBOL, POS_OUT_W'(sl), POS_OUT_W'(sc)));
          default: ;
        endcase
      end
      push_res(b, n, eoi_res(POS_OUT_W'(nl), POS_OUT_W'(nc)));
      ctl_o        = '{mode: M_IDLE, pending: 8'h00, halted: 1'b0};
      cur_line_o   = PosOne;
      cur_col_o    = PosOne;
      start_line_o = PosOne;
      start_col_o  = PosOne;
    end else begin
      ctl_o        = '{mode: mode, pending: pend, halted: halt};
      cur_line_o   = nl;
      cur_col_o    = nc;
      start_line_o = sl;
      start_col_o  = sc;
    end

    if (n != '0) b[IDX_W'(n - CNT_W'(1))].eor = 1'b1;
    bundle_o = b;
    count_o  = n;
  end

endmodule

[design/sexpr_token_scanner_unit.sv]
`timescale 1ns / 1ps

`include "sexpr_token_scanner_unit_assert.svh"

// S-expression token scanner. Source text enters one byte per transfer on
// in_i, with last marking the final byte of a text; token events leave on
// out_o, one per transfer: each token character (string characters already
// unescaped, quotes dropped), a token end carrying the final kind, lexical
// errors, and end of input after the final byte. Every event carries the line
// and column where its token started (or where the error sits). A byte is
// scanned in the cycle of its transfer and its events, between zero and five,
// are captured together in a small result bundle register; the first one is
// offered on out_o in the next cycle. A byte with events holds the input side
// until its last event transfers, so the block sustains one byte per cycle
// whenever each byte yields at most one event and the sink keeps ready high,
// and a new byte is taken in the same cycle that the last event of the
// previous byte transfers. The figure is set by the single output port, which
// moves one event per cycle. Positions count from 1 and saturate at
// 2^POSITION_BITS - 1; the outputs carry the low 16 bits. After an error the
// scanner stays silent until the final byte, which reports only end of input
// and returns everything to its reset state. No clearing pass follows reset.
module sexpr_token_scanner_unit import sts_pkg::*; #(
  parameter int unsigned POSITION_BITS = POS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sts_byte_if.sink    in_i,
  sts_event_if.source out_o
);

  localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);

  // Scanner state.
  mode_e                    mode_q;
  logic [7:0]               pending_q;
  logic                     halted_q;
  logic [POSITION_BITS-1:0] cur_line_q, cur_col_q, start_line_q, start_col_q;

  // Result bundle of the byte being drained.
  bundle_t                  bundle_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [IDX_W-1:0]         idx_q;

  scan_ctl_t                ctl_cur, ctl_d;
  logic [POSITION_BITS-1:0] cur_line_d, cur_col_d, start_line_d, start_col_d;
  bundle_t                  bundle_d;
  logic [CNT_W-1:0]         cnt_d;

  logic                     last_slot;
  logic                     in_fire;
  logic                     out_fire;
  result_t                  head;

  assign ctl_cur = '{mode: mode_q, pending: pending_q, halted: halted_q};

  sts_scan_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .ch_i         (in_i.ch),
    .last_i       (in_i.last),
    .ctl_i        (ctl_cur),
    .cur_line_i   (cur_line_q),
    .cur_col_i    (cur_col_q),
    .start_line_i (start_line_q),
    .start_col_i  (start_col_q),
    .ctl_o        (ctl_d),
    .cur_line_o   (cur_line_d),
    .cur_col_o    (cur_col_d),
    .start_line_o (start_line_d),
    .start_col_o  (start_col_d),
    .bundle_o     (bundle_d),
    .count_o      (cnt_d)
  );

  // The bundle is emptied front to back; the input side opens as soon as the
  // last buffered event is being taken, so no cycle is lost between bytes.
  assign last_slot  = (CNT_W'(idx_q) == cnt_q - CNT_W'(1));
  assign out_fire   = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q == '0) || (out_o.ready && last_slot);
  assign in_fire    = in_i.valid && in_i.ready;

  assign head             = bundle_q[idx_q];
  assign out_o.valid      = (cnt_q != '0);
  assign out_o.event_res  = head.ev;
  assign out_o.kind       = head.kind;
  assign out_o.value      = head.value;
  assign out_o.line       = head.line;
  assign out_o.column     = head.column;
  assign out_o.error_code = head.err;
  assign out_o.end_of_run = head.eor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= M_IDLE;
      pending_q    <= 8'h00;
      halted_q     <= 1'b0;
      cur_line_q   <= PosOne;
      cur_col_q    <= PosOne;
      start_line_q <= PosOne;
      start_col_q  <= PosOne;
      cnt_q        <= '0;
      idx_q        <= '0;
    end else begin
      if (in_fire) begin
        mode_q       <= ctl_d.mode;
        pending_q    <= ctl_d.pending;
        halted_q     <= ctl_d.halted;
        cur_line_q   <= cur_line_d;
        cur_col_q    <= cur_col_d;
        start_line_q <= start_line_d;
        start_col_q  <= start_col_d;
        cnt_q        <= cnt_d;
        idx_q        <= '0;
      end else if (out_fire) begin
        if (last_slot) begin
          cnt_q <= '0;
          idx_q <= '0;
        end else begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
    end
  end

  // Event payload needs no reset; the count qualifies it.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bundle_q <= bundle_d;
    end
  end

  // The drain index never runs past the number of buffered events.
  `STS_ASSERT_ALWAYS(a_idx_in_range, clk_i, rst_ni,
                     (cnt_q == '0) || (CNT_W'(idx_q) < cnt_q), "drain index beyond bundle")
  // An error always leaves the scanner between tokens.
  `STS_ASSERT_ALWAYS(a_halt_idle, clk_i, rst_ni,
                     !halted_q || (mode_q == M_IDLE), "halted outside idle mode")
  // The end-of-run flag marks exactly the final buffered event.
  `STS_ASSERT_IMPL(a_eor_last, clk_i, rst_ni, out_o.valid,
                   out_o.end_of_run == last_slot, "end_of_run misplaced")
  // The final byte of a text brings the scanner back to its reset state.
  `STS_ASSERT_NEXT(a_last_resets, clk_i, rst_ni, in_fire && in_i.last,
                   (mode_q == M_IDLE) && !halted_q && (cur_line_q == PosOne) &&
                   (cur_col_q == PosOne), "state not restored after final byte")

endmodule

[test/token_event_checker.sv]
`timescale 1ns / 1ps

module token_event_checker import sts_pkg::*; #(
  parameter int unsigned POSITION_BITS = POS_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  sts_byte_if  byte_i,
  sts_event_if event_i,
  output int   mismatches_o,
  output int   waiting_o,
  output int   checked_o
);

  localparam logic [31:0] POS_MAX = 32'((64'd1 << POSITION_BITS) - 64'd1);

  // Shadow copy of the scanner state.
  mode_e       scan_state;
  logic [7:0]  held_byte;
  logic [31:0] line_now;
  logic [31:0] col_now;
  logic [31:0] tok_line;
  logic [31:0] tok_col;
  logic        stopped;

  result_t     step_events [MAX_RES];
  int          step_count;
  result_t     expected_events [$];
  result_t     want;
  int          mismatches;
  int          checked;

  assign mismatches_o = mismatches;
  assign checked_o    = checked;

  function automatic logic blank_byte(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic break_byte(input logic [7:0] c);
    return blank_byte(c) || (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_QUOTE);
  endfunction

  function automatic void restart_text();
    scan_state = M_IDLE;
    held_byte  = 8'h00;
    line_now   = 32'd1;
    col_now    = 32'd1;
    tok_line   = 32'd1;
    tok_col    = 32'd1;
    stopped    = 1'b0;
  endfunction

  function automatic void add_event(input event_e ev, input kind_e k, input logic [7:0] v,
                                    input logic [31:0] ln, input logic [31:0] col,
                                    input err_e code);
    if (step_count < MAX_RES) begin
      step_events[step_count] = '{ev: ev, kind: k, value: v, line: ln[POS_OUT_W-1:0],
                                  column: col[POS_OUT_W-1:0], err: code, eor: 1'b0};
      step_count++;
    end
  endfunction

  function automatic void tok_char(input kind_e k, input logic [7:0] v);
    add_event(EV_CHAR, k, v, tok_line, tok_col, ERR_NONE);
  endfunction

  function automatic void tok_end(input kind_e k);
    add_event(EV_END, k, 8'h00, tok_line, tok_col, ERR_NONE);
  endfunction

  function automatic void scan_error(input err_e code, input logic [31:0] ln,
                                     input logic [31:0] col);
    add_event(EV_ERROR, K_LPAREN, 8'h00, ln, col, code);
    stopped    = 1'b1;
    scan_state = M_IDLE;
  endfunction

  // Works out every event that one accepted byte causes and queues them.
  function automatic void predict_byte(input logic [7:0] c, input logic fin);
    logic [31:0] nl;
    logic [31:0] nc;
    logic        again;
    kind_e       tok_kind;
    int          i;
    step_count = 0;
    nl = line_now;
    nc = col_now;
    if (c == CH_NEWLINE) begin
      if (nl < POS_MAX) nl = nl + 32'd1;
      nc = 32'd1;
    end else if (nc < POS_MAX) begin
      nc = nc + 32'd1;
    end
    if (!stopped) begin
      // A byte may close one token and then be scanned again from idle.
      do begin
        again = 1'b0;
        case (scan_state)
          M_IDLE: begin
            if (!blank_byte(c)) begin
              tok_line = line_now;
              tok_col  = col_now;
              if ((c == CH_LPAREN) || (c == CH_RPAREN)) begin
                tok_kind = (c == CH_LPAREN) ? K_LPAREN : K_RPAREN;
                tok_char(tok_kind, c);
                tok_end(tok_kind);
              end else if (c == CH_DOT) begin
                scan_state = M_PDOT;
                held_byte  = c;
              end else if (c == CH_QUOTE) begin
                scan_state = M_STR;
              end else if (digit_byte(c)) begin
                tok_char(K_INT, c);
                scan_state = M_INT;
              end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                scan_state = M_PSIGN;
                held_byte  = c;
              end else begin
                scan_state = M_SYM;
                again      = 1'b1;
              end
            end
          end
          M_PDOT: begin
            if (digit_byte(c)) begin
              scan_error(ERR_DOT_DIGIT, tok_line, tok_col);
            end else begin
              tok_char(K_DOT, CH_DOT);
              tok_end(K_DOT);
              scan_state = M_IDLE;
              again      = 1'b1;
            end
          end
          M_PSIGN: begin
            if (digit_byte(c)) begin
              tok_char(K_INT, held_byte);
              tok_char(K_INT, c);
              scan_state = M_INT;
            end else begin
              tok_char(K_SYMBOL, held_byte);
              scan_state = M_SYM;
              again      = 1'b1;
            end
          end
          M_INT, M_FRAC: begin
            tok_kind = (scan_state == M_INT) ? K_INT : K_FLOAT;
            if (digit_byte(c)) begin
              tok_char(tok_kind, c);
            end else if ((c == CH_DOT) && (scan_state == M_INT)) begin
              tok_char(K_FLOAT, c);
              scan_state = M_FRAC0;
            end else if (break_byte(c)) begin
              tok_end(tok_kind);
              scan_state = M_IDLE;
              again      = 1'b1;
            end else begin
              scan_error(ERR_BAD_NUMBER, tok_line, tok_col);
            end
          end
          M_FRAC0: begin
            if (digit_byte(c)) begin
              tok_char(K_FLOAT, c);
              scan_state = M_FRAC;
            end else begin
              scan_error(ERR_NO_FRACTION, tok_line, tok_col);
            end
          end
          M_STR: begin
            if (c == CH_QUOTE) begin
              tok_end(K_STRING);
              scan_state = M_IDLE;
            end else if (c == CH_BSLASH) begin
              scan_state = M_ESC;
            end else begin
              tok_char(K_STRING, c);
            end
          end
          M_ESC: begin
            if (c == CH_N) begin
              tok_char(K_STRING, CH_NEWLINE);
              scan_state = M_STR;
            end else if (c == CH_T) begin
              tok_char(K_STRING, CH_TAB);
              scan_state = M_STR;
            end else if ((c == CH_QUOTE) || (c == CH_BSLASH)) begin
              tok_char(K_STRING, c);
              scan_state = M_STR;
            end else begin
              scan_error(ERR_BAD_ESCAPE, nl, nc);
            end
          end
          M_SYM: begin
            if (break_byte(c)) begin
              tok_end(K_SYMBOL);
              scan_state = M_IDLE;
              again      = 1'b1;
            end else if (c == CH_DOT) begin
              scan_error(ERR_DOT_SYMBOL, line_now, col_now);
            end else begin
              tok_char(K_SYMBOL, c);
            end
          end
          default: begin
            scan_state = M_IDLE;
            again      = 1'b1;
          end
        endcase
      end while (again);
    end
    line_now = nl;
    col_now  = nc;
    if (fin) begin
      // The final byte completes whatever token is still open.
      if (!stopped) begin
        case (scan_state)
          M_PDOT: begin
            tok_char(K_DOT, CH_DOT);
            tok_end(K_DOT);
          end
          M_PSIGN: begin
            tok_char(K_SYMBOL, held_byte);
            tok_end(K_SYMBOL);
          end
          M_INT:        tok_end(K_INT);
          M_FRAC:       tok_end(K_FLOAT);
          M_FRAC0:      scan_error(ERR_NO_FRACTION, tok_line, tok_col);
          M_STR, M_ESC: scan_error(ERR_OPEN_STRING, tok_line, tok_col);
          M_SYM:        tok_end(K_SYMBOL);
          default: ;
        endcase
      end
      add_event(EV_EOI, K_LPAREN, 8'h00, line_now, col_now, ERR_NONE);
      restart_text();
    end
    if (step_count > 0) step_events[step_count-1].eor = 1'b1;
    for (i = 0; i < step_count; i++) begin
      expected_events.insert(expected_events.size(), step_events[i]);
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_val,
                                      input logic [15:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endfunction

  // Outputs are compared before the new byte is predicted, so an event that
  // shows up with nothing waiting is never hidden by this edge's predictions.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_text();
      expected_events.delete();
      mismatches = 0;
      checked    = 0;
      waiting_o <= 0;
    end else begin
      if (event_i.valid && event_i.ready) begin
        if (expected_events.size() == 0) begin
          $error("event_res %0d arrived with no event expected", event_i.event_res);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", 16'(want.ev), 16'(event_i.event_res));
          check_field("kind", 16'(want.kind), 16'(event_i.kind));
          check_field("value", 16'(want.value), 16'(event_i.value));
          check_field("line", want.line, event_i.line);
          check_field("column", want.column, event_i.column);
          check_field("error_code", 16'(want.err), 16'(event_i.error_code));
          check_field("end_of_run", 16'(want.eor), 16'(event_i.end_of_run));
          checked++;
        end
      end
      if (byte_i.valid && byte_i.ready) predict_byte(byte_i.ch, byte_i.last);
      waiting_o <= expected_events.size();
    end
  end

endmodule

[test/tb_sexpr_token_scanner_unit.sv]
`timescale 1ns / 1ps

module tb_sexpr_token_scanner_unit;
  import sts_pkg::*;

  // The run is stopped as failed if it ever gets this far.
  localparam int CYCLE_LIMIT  = 1000000;
  // Random text stops once this many bytes have been sent in total.
  localparam int ITEM_COUNT   = 120;
  // Quiet cycles after the last expected event, to catch stray events.
  localparam int DRAIN_CYCLES = 20;

  logic       clk_i;
  logic       rst_ni;
  // While set, neither side idles, so the block runs at full rate.
  logic       quiet;
  int         mismatch_count;
  int         events_waiting;
  int         events_checked;
  int         text_total;
  int         byte_total;
  int         cycle_count;
  logic [7:0] text_bytes [$];

  sts_byte_if  byte_ch ();
  sts_event_if event_ch ();

  sexpr_token_scanner_unit #(
    .POSITION_BITS(POS_BITS_DEF)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_ch),
    .out_o (event_ch)
  );

  // The checker watches both channels, predicts every event and compares.
  token_event_checker #(
    .POSITION_BITS(POS_BITS_DEF)
  ) event_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_ch),
    .event_i     (event_ch),
    .mismatches_o(mismatch_count),
    .waiting_o   (events_waiting),
    .checked_o   (events_checked)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Adds one byte to the end of the text being built.
  function automatic void append_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endfunction

  // Offers one byte and holds it until the transfer happens. Valid is only
  // lowered when an idle gap follows, so it is never lowered and raised again
  // within the same time step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.ch    <= b;
    byte_ch.last  <= fin;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  // Sends the collected text, marking its final byte, and empties it.
  task automatic send_text();
    int i;
    for (i = 0; i < text_bytes.size(); i++) send_byte(text_bytes[i], i == text_bytes.size() - 1);
    byte_total += text_bytes.size();
    text_total++;
    text_bytes.delete();
  endtask

  function automatic void add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  function automatic void push_digit();
    append_byte(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // A number may carry a leading sign, one time in three of each kind.
  function automatic void push_sign();
    case ($urandom_range(0, 2))
      0:       append_byte(CH_PLUS);
      1:       append_byte(CH_MINUS);
      default: ;
    endcase
  endfunction

  // Any byte that can open a symbol: not a delimiter, digit, sign or dot.
  function automatic logic [7:0] symbol_start_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (is_delim(b) || is_digit(b) || (b == CH_DOT) || (b == CH_PLUS) || (b == CH_MINUS));
    return b;
  endfunction

  function automatic logic [7:0] symbol_rest_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_delim(b) || (b == CH_DOT));
    return b;
  endfunction

  // Separates tokens with one or two whitespace bytes, and now and then with
  // none at all so that neighbors run into each other.
  function automatic void add_blank();
    int n;
    int i;
    logic [7:0] b;
    n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2);
    for (i = 0; i < n; i++) begin
      b = 8'($urandom_range(8, 13));
      append_byte((b == 8'd8) ? CH_SPACE : b);
    end
  endfunction

  // Appends one random token. Most tokens are well formed; a few are noise
  // bytes, and a few are broken on purpose. A broken token ends its text,
  // since the scanner ignores everything after an error anyway; the return
  // value says so.
  function automatic bit add_token();
    int sel;
    int n;
    int i;
    logic [7:0] b;
    sel = $urandom_range(0, 19);
    if (sel <= 1) begin
      append_byte(CH_LPAREN);
    end else if (sel <= 3) begin
      append_byte(CH_RPAREN);
    end else if (sel <= 6) begin
      append_byte(symbol_start_byte());
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) append_byte(symbol_rest_byte());
    end else if (sel <= 9) begin
      push_sign();
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) push_digit();
    end else if (sel <= 11) begin
      push_sign();
      push_digit();
      if ($urandom_range(0, 1) != 0) push_digit();
      append_byte(CH_DOT);
      push_digit();
      if ($urandom_range(0, 1) != 0) push_digit();
    end else if (sel <= 14) begin
      // String with a mix of plain bytes and every legal escape.
      append_byte(CH_QUOTE);
      n = $urandom_range(0, 4);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          append_byte(CH_BSLASH);
          case ($urandom_range(0, 3))
            0:       append_byte(CH_N);
            1:       append_byte(CH_T);
            2:       append_byte(CH_QUOTE);
            default: append_byte(CH_BSLASH);
          endcase
        end else begin
          do b = 8'($urandom_range(0, 255)); while ((b == CH_QUOTE) || (b == CH_BSLASH));
          append_byte(b);
        end
      end
      append_byte(CH_QUOTE);
    end else if (sel == 15) begin
      append_byte(CH_DOT);
    end else if (sel == 16) begin
      // A sign that turns out to open a symbol, or stands alone.
      append_byte(($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS);
      n = $urandom_range(0, 2);
      for (i = 0; i < n; i++) append_byte(symbol_rest_byte());
    end else if (sel == 17) begin
      n = $urandom_range(1, 2);
      for (i = 0; i < n; i++) append_byte(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 5))
        0: begin
          // Dot directly followed by a digit.
          append_byte(CH_DOT);
          push_digit();
        end
        1: begin
          // Decimal point with no fraction digit, either at the end of the
          // text or before some other byte.
          push_digit();
          append_byte(CH_DOT);
          if ($urandom_range(0, 1) != 0) begin
            do b = 8'($urandom_range(0, 255)); while (is_digit(b));
            append_byte(b);
          end
        end
        2: begin
          // Number running into a byte that is not a delimiter.
          push_digit();
          do b = 8'($urandom_range(0, 255));
          while (is_delim(b) || is_digit(b) || (b == CH_DOT));
          append_byte(b);
        end
        3: begin
          // Backslash followed by a byte that is not a legal escape.
          append_byte(CH_QUOTE);
          append_byte(CH_BSLASH);
          do b = 8'($urandom_range(0, 255));
          while ((b == CH_N) || (b == CH_T) || (b == CH_QUOTE) || (b == CH_BSLASH));
          append_byte(b);
        end
        4: begin
          // String left open when the text ends, sometimes right after a
          // backslash.
          append_byte(CH_QUOTE);
          n = $urandom_range(0, 2);
          for (i = 0; i < n; i++) begin
            do b = 8'($urandom_range(0, 255)); while ((b == CH_QUOTE) || (b == CH_BSLASH));
            append_byte(b);
          end
          if ($urandom_range(0, 1) != 0) append_byte(CH_BSLASH);
        end
        default: begin
          // Dot inside a symbol.
          append_byte(symbol_start_byte());
          append_byte(CH_DOT);
        end
      endcase
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Event sink: before every transfer it may stall with ready low, unless quiet
  // is set, then it holds ready high until an event actually moves.
  initial begin
    int unsigned stall;
    event_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        event_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      event_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!event_ch.valid);
    end
  end

  // Watchdog: a hung handshake ends the run as failed.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int ntok;
    int i;
    quiet      = 1'b0;
    text_total = 0;
    byte_total = 0;
    rst_ni        <= 1'b0;
    byte_ch.valid <= 1'b0;
    byte_ch.ch    <= 8'h00;
    byte_ch.last  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed texts. A pending dot and a pending sign each resolved by a
    // parenthesis on the final byte give the largest event bursts.
    add_str("(.(");
    send_text();
    add_str("+(");
    send_text();
    // Every escape, then a string left open at the end of the text.
    add_str("\"\\n\\t\\\\\\\"x");
    send_text();
    // One text for each of the other lexical errors.
    add_str(".5");
    send_text();
    add_str("1.");
    send_text();
    add_str("1a");
    send_text();
    add_str("\"\\q");
    send_text();
    add_str("a.");
    send_text();
    // Extreme byte values inside a symbol that the final byte completes.
    append_byte(8'h00);
    append_byte(8'hFF);
    send_text();
    // Signed decimal completed by the final byte.
    add_str("-3.5");
    send_text();

    // Random token streams; about one text in four runs with no idling.
    while (byte_total < ITEM_COUNT) begin
      quiet = ($urandom_range(0, 3) == 0);
      ntok  = $urandom_range(1, 8);
      for (i = 0; i < ntok; i++) begin
        if (add_token()) break;
        if ((i != ntok - 1) || ($urandom_range(0, 1) != 0)) add_blank();
      end
      send_text();
    end
    quiet = 1'b0;
    byte_ch.valid <= 1'b0;

    // Wait until every predicted event has transferred, then stay a while
    // longer so that any stray event is still caught.
    do @(posedge clk_i); while (events_waiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Scanned %0d texts (%0d bytes); %0d events compared.",
             text_total, byte_total, events_checked);
    $display("Covered every token kind, every escape, all six lexical errors and random stalls.");
    if ((mismatch_count == 0) && (events_waiting == 0)) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
